>>> sv/additive_pixel_buffer_with_fade_macros.svh
// assertion macros used by the rtl datapath (apbf_dp)
`ifndef ADDITIVE_PIXEL_BUFFER_WITH_FADE_MACROS_SVH
`define ADDITIVE_PIXEL_BUFFER_WITH_FADE_MACROS_SVH

// same-cycle implication
`define APBF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/apbf_pkg.sv
`default_nettype none

package apbf_pkg;

	localparam int IDX_W       = 12;
	localparam int CHAN_W      = 8;
	localparam int GAIN_W      = 9;
	localparam int TYPE_W      = 2;
	localparam int PIXEL_COUNT = 1024;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd256;

	localparam logic [TYPE_W-1:0] REQ_ADD  = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_FADE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_READ = 2'd2;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [IDX_W-1:0]  pixel_index;
		logic [CHAN_W-1:0] add_red;
		logic [CHAN_W-1:0] add_green;
		logic [CHAN_W-1:0] add_blue;
	} req_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0]  out_index;
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic              status;
	} rsp_beat_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic sweep_rd;
		logic respond;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_fade;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> sv/additive_pixel_buffer_with_fade.sv
// channel   dir  handshake             payload
// req       in   req_valid/req_stall   req_beat  (add, fade, read)
// rsp       out  rsp_valid/rsp_stall   rsp_beat  (one beat per request)
// cfg       in   cfg_wen               cfg_wdata (fade gain, q1.8)
//
// add and read: memory read, then for add a saturating add and write-back
// fade sweeps every pixel, one pixel per cycle through the memory port
// after reset a clearing pass over every pixel runs with req_stall high
// a stalled result beat holds the block before its write-back and reply
`default_nettype none

module additive_pixel_buffer_with_fade #(
	parameter int PIXEL_COUNT = apbf_pkg::PIXEL_COUNT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire apbf_pkg::req_beat_t         req_beat,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output apbf_pkg::rsp_beat_t              rsp_beat,
	input  wire logic                        cfg_wen,
	input  wire logic [apbf_pkg::GAIN_W-1:0] cfg_wdata
);

	localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

	apbf_pkg::ctl_cmd_t   cmd;
	apbf_pkg::dp_status_t st;
	logic [AW-1:0]        sweep_addr;

	apbf_ctrl #(
		.PIXEL_COUNT(PIXEL_COUNT),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd),
		.sweep_addr(sweep_addr)
	);

	apbf_dp #(
		.PIXEL_COUNT(PIXEL_COUNT),
		.AW         (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_beat  (req_beat),
		.rsp_beat  (rsp_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sweep_addr(sweep_addr),
		.st        (st)
	);

endmodule

`default_nettype wire

>>> sv/apbf_ctrl.sv
`default_nettype none

module apbf_ctrl #(
	parameter int PIXEL_COUNT = apbf_pkg::PIXEL_COUNT,
	parameter int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire apbf_pkg::dp_status_t st,
	output apbf_pkg::ctl_cmd_t        cmd,
	output logic [AW-1:0]             sweep_addr
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_FADE,
		ST_FADE_END
	} state_t;

	localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);

	state_t        state_q;
	logic [AW-1:0] cnt_q;
	logic          last;

	assign last       = (cnt_q == LAST_ADDR);
	assign sweep_addr = cnt_q;
	assign req_stall  = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == ST_IDLE) && req_valid;
		cmd.clr_wr   = (state_q == ST_CLEAR);
		cmd.sweep_rd = (state_q == ST_FADE);
		cmd.respond  = ((state_q == ST_ACCESS) || (state_q == ST_FADE_END)) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						cnt_q   <= '0;
						state_q <= st.req_fade ? ST_FADE : ST_ACCESS;
					end
				end
				ST_ACCESS: begin
					if (st.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FADE: begin
					cnt_q <= cnt_q + AW'(1);
					if (last) begin
						cnt_q   <= '0;
						state_q <= ST_FADE_END;
					end
				end
				ST_FADE_END: begin
					if (st.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/apbf_dp.sv
`default_nettype none
`include "additive_pixel_buffer_with_fade_macros.svh"

module apbf_dp #(
	parameter int PIXEL_COUNT = apbf_pkg::PIXEL_COUNT,
	parameter int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire apbf_pkg::req_beat_t                  req_beat,
	output apbf_pkg::rsp_beat_t                       rsp_beat,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_stall,
	input  wire logic                                 cfg_wen,
	input  wire logic [apbf_pkg::GAIN_W-1:0]          cfg_wdata,
	input  wire apbf_pkg::ctl_cmd_t                   cmd,
	input  wire logic [AW-1:0]                        sweep_addr,
	output apbf_pkg::dp_status_t                      st
);

	localparam int CW = apbf_pkg::CHAN_W;
	localparam int GW = apbf_pkg::GAIN_W;
	localparam int IW = apbf_pkg::IDX_W;
	localparam logic [IW:0] COUNT_X = (IW+1)'(PIXEL_COUNT);

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? {CW{1'b1}} : s[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] fade_chan(input logic [CW-1:0] c, input logic [GW-1:0] g);
		logic [CW+GW-1:0] p;
		logic [GW-1:0]    v;
		p = {{GW{1'b0}}, c} * {{CW{1'b0}}, g};
		v = p[CW+GW-1:CW];
		return v[GW-1] ? {CW{1'b1}} : v[CW-1:0];
	endfunction

	apbf_pkg::pixel_t    mem [PIXEL_COUNT];
	apbf_pkg::pixel_t    rdata_q;
	apbf_pkg::req_beat_t req_s1;
	logic                in_range_s1;
	logic [AW-1:0]       wr_addr_s1;
	logic                sweep_vld_s1;
	logic [GW-1:0]       gain_q;
	logic                rsp_valid_q;
	apbf_pkg::rsp_beat_t rsp_q;

	logic                in_range;
	logic                req_ok_s1;
	logic                is_add_s1;
	apbf_pkg::pixel_t    sum;
	apbf_pkg::pixel_t    faded;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	apbf_pkg::pixel_t    mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	apbf_pkg::rsp_beat_t rsp_next;

	assign in_range  = ({1'b0, req_beat.pixel_index} < COUNT_X);
	assign is_add_s1 = (req_s1.req_type == apbf_pkg::REQ_ADD);
	assign req_ok_s1 = in_range_s1 &&
		(is_add_s1 || (req_s1.req_type == apbf_pkg::REQ_READ));

	assign sum.red     = sat_add(rdata_q.red, req_s1.add_red);
	assign sum.green   = sat_add(rdata_q.green, req_s1.add_green);
	assign sum.blue    = sat_add(rdata_q.blue, req_s1.add_blue);
	assign faded.red   = fade_chan(rdata_q.red, gain_q);
	assign faded.green = fade_chan(rdata_q.green, gain_q);
	assign faded.blue  = fade_chan(rdata_q.blue, gain_q);

	// single write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_addr;
		mem_wdata = '0;
		if (cmd.clr_wr) begin
			mem_we = 1'b1;
		end else if (sweep_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = faded;
		end else if (cmd.respond && is_add_s1 && in_range_s1) begin
			mem_we    = 1'b1;
			mem_waddr = req_s1.pixel_index[AW-1:0];
			mem_wdata = sum;
		end
	end

	// single read port
	always_comb begin
		mem_re    = cmd.sweep_rd;
		mem_raddr = sweep_addr;
		if (cmd.accept) begin
			mem_re    = in_range && (req_beat.req_type == apbf_pkg::REQ_ADD ||
				req_beat.req_type == apbf_pkg::REQ_READ);
			mem_raddr = req_beat.pixel_index[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_s1      <= req_beat;
			in_range_s1 <= in_range;
		end
		wr_addr_s1 <= sweep_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_vld_s1 <= 1'b0;
			gain_q       <= apbf_pkg::GAIN_RESET;
		end else begin
			sweep_vld_s1 <= cmd.sweep_rd;
			if (cfg_wen) begin
				gain_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		rsp_next           = '0;
		rsp_next.out_index = req_s1.pixel_index;
		if (req_ok_s1) begin
			rsp_next.out_red   = is_add_s1 ? sum.red   : rdata_q.red;
			rsp_next.out_green = is_add_s1 ? sum.green : rdata_q.green;
			rsp_next.out_blue  = is_add_s1 ? sum.blue  : rdata_q.blue;
		end
		rsp_next.status = (req_s1.req_type != apbf_pkg::REQ_FADE) && !req_ok_s1;
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.respond) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign rsp_beat    = rsp_q;
	assign st.out_free = !rsp_valid_q || !rsp_stall;
	assign st.req_fade = (req_beat.req_type == apbf_pkg::REQ_FADE);

	`APBF_ASSERT_NOW(a_no_rw_collide, mem_we && mem_re && sweep_vld_s1, mem_waddr != mem_raddr, "fade write collides with read")
	`APBF_ASSERT_NOW(a_respond_free, cmd.respond, !(rsp_valid_q && rsp_stall), "beat overwritten while stalled")
	`APBF_ASSERT_NEXT(a_fade_status, cmd.respond && req_s1.req_type == apbf_pkg::REQ_FADE, rsp_valid && !rsp_beat.status, "fade beat flagged")
	`APBF_ASSERT_NOW(a_add_in_range, mem_we && !sweep_vld_s1 && !cmd.clr_wr, in_range_s1 && is_add_s1, "write outside an in-range add")

endmodule

`default_nettype wire

>>> tb/sv/tb_additive_pixel_buffer_with_fade.sv
`default_nettype none

module tb_additive_pixel_buffer_with_fade;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW = (apbf_pkg::PIXEL_COUNT > 1) ? $clog2(apbf_pkg::PIXEL_COUNT) : 1;

	typedef logic [apbf_pkg::TYPE_W-1:0] type_t;
	typedef logic [apbf_pkg::IDX_W-1:0]  idx_t;
	typedef logic [apbf_pkg::IDX_W:0]    span_t;
	typedef logic [apbf_pkg::CHAN_W-1:0] chan_t;
	typedef logic [apbf_pkg::GAIN_W-1:0] gain_t;
	typedef logic [AW-1:0]               addr_t;

	localparam type_t REQ_RSVD = 2'd3;
	localparam span_t COUNT_X  = span_t'(apbf_pkg::PIXEL_COUNT);
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RAND_ITEMS  = 1700;
	localparam int PHASES      = 8;
	localparam int CALM_ITEMS  = 150;

	typedef struct {
		apbf_pkg::req_beat_t req;
		bit                  typed;
		apbf_pkg::rsp_beat_t rsp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	apbf_pkg::req_beat_t req_beat = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	apbf_pkg::rsp_beat_t rsp_beat;
	logic cfg_wen = 1'b0;
	gain_t cfg_wdata = '0;

	apbf_pkg::pixel_t frame_model [apbf_pkg::PIXEL_COUNT];
	gain_t gain_model = apbf_pkg::GAIN_RESET;
	apbf_pkg::rsp_beat_t rsp_due [$];
	dir_row_t dir_rows [$];
	int mismatches = 0;
	int cycle_cnt = 0;
	int hold_cnt = 0;
	bit calm = 1'b0;

	additive_pixel_buffer_with_fade DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_beat  (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side stall bursts
	always @(posedge clk) begin
		if (calm) begin
			rsp_stall <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (rsp_stall) begin
			rsp_stall <= 1'b0;
			hold_cnt <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 20);
		end else if ($urandom_range(0, 4) == 0) begin
			rsp_stall <= 1'b1;
			hold_cnt <= $urandom_range(0, 12);
		end
	end

	function automatic chan_t sat_sum(input chan_t a, input chan_t b);
		logic [apbf_pkg::CHAN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[apbf_pkg::CHAN_W] ? {apbf_pkg::CHAN_W{1'b1}} : s[apbf_pkg::CHAN_W-1:0];
	endfunction

	function automatic chan_t faded(input chan_t c);
		logic [apbf_pkg::CHAN_W+apbf_pkg::GAIN_W-1:0] p;
		gain_t v;
		p = {{apbf_pkg::GAIN_W{1'b0}}, c} * {{apbf_pkg::CHAN_W{1'b0}}, gain_model};
		v = p[apbf_pkg::CHAN_W+apbf_pkg::GAIN_W-1:apbf_pkg::CHAN_W];
		return v[apbf_pkg::GAIN_W-1] ? {apbf_pkg::CHAN_W{1'b1}} : v[apbf_pkg::CHAN_W-1:0];
	endfunction

	// updates the frame model and returns the expected result beat
	function automatic apbf_pkg::rsp_beat_t apply_request(input apbf_pkg::req_beat_t q);
		apbf_pkg::rsp_beat_t r;
		addr_t a;
		r = '0;
		a = q.pixel_index[AW-1:0];
		r.out_index = q.pixel_index;
		case (q.req_type) inside
			apbf_pkg::REQ_FADE: begin
				foreach (frame_model[i]) begin
					frame_model[i].red   = faded(frame_model[i].red);
					frame_model[i].green = faded(frame_model[i].green);
					frame_model[i].blue  = faded(frame_model[i].blue);
				end
			end
			apbf_pkg::REQ_ADD, apbf_pkg::REQ_READ: begin
				if ({1'b0, q.pixel_index} >= COUNT_X) begin
					r.status = 1'b1;
				end else begin
					if (q.req_type == apbf_pkg::REQ_ADD) begin
						frame_model[a].red   = sat_sum(frame_model[a].red, q.add_red);
						frame_model[a].green = sat_sum(frame_model[a].green, q.add_green);
						frame_model[a].blue  = sat_sum(frame_model[a].blue, q.add_blue);
					end
					r.out_red   = frame_model[a].red;
					r.out_green = frame_model[a].green;
					r.out_blue  = frame_model[a].blue;
				end
			end
			default: begin
				r.status = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic void add_row(input type_t t, input int idx, input int ar, input int ag,
			input int ab, input int typed, input int er, input int eg, input int eb,
			input int est);
		dir_row_t row;
		row.req = '{req_type: t, pixel_index: idx_t'(idx), add_red: chan_t'(ar),
			add_green: chan_t'(ag), add_blue: chan_t'(ab)};
		row.typed = (typed != 0);
		row.rsp = '{out_index: idx_t'(idx), out_red: chan_t'(er), out_green: chan_t'(eg),
			out_blue: chan_t'(eb), status: 1'(est)};
		dir_rows.push_back(row);
	endfunction

	function automatic chan_t rand_amount();
		return chan_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, 40));
	endfunction

	function automatic apbf_pkg::req_beat_t make_random_req();
		apbf_pkg::req_beat_t q;
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			q.req_type = apbf_pkg::REQ_ADD;
		else if (r < 91)
			q.req_type = apbf_pkg::REQ_READ;
		else if (r < 95)
			q.req_type = apbf_pkg::REQ_FADE;
		else
			q.req_type = REQ_RSVD;
		r = $urandom_range(0, 9);
		if (r < 6)
			q.pixel_index = idx_t'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) :
				$urandom_range(apbf_pkg::PIXEL_COUNT - 8, apbf_pkg::PIXEL_COUNT - 1));
		else if (r < 8)
			q.pixel_index = idx_t'($urandom_range(0, apbf_pkg::PIXEL_COUNT - 1));
		else if (r < 9)
			q.pixel_index = idx_t'($urandom_range(apbf_pkg::PIXEL_COUNT, 4095));
		else
			q.pixel_index = idx_t'($urandom_range(0, 4095));
		q.add_red   = rand_amount();
		q.add_green = rand_amount();
		q.add_blue  = rand_amount();
		return q;
	endfunction

	always @(posedge clk) begin
		apbf_pkg::rsp_beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", rsp_beat);
			end else begin
				want = rsp_due.pop_front();
				if (rsp_beat.out_index !== want.out_index || rsp_beat.out_red !== want.out_red
						|| rsp_beat.out_green !== want.out_green
						|| rsp_beat.out_blue !== want.out_blue
						|| rsp_beat.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp idx %h rgb %h/%h/%h st %b, ",
							"got idx %h rgb %h/%h/%h st %b"},
							want.out_index, want.out_red, want.out_green, want.out_blue,
							want.status, rsp_beat.out_index, rsp_beat.out_red,
							rsp_beat.out_green, rsp_beat.out_blue, rsp_beat.status);
				end
			end
		end
	end

	task automatic send_beat(input apbf_pkg::req_beat_t q, input bit typed,
			input apbf_pkg::rsp_beat_t want);
		apbf_pkg::rsp_beat_t model_rsp;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_beat <= q;
		do @(posedge clk); while (req_stall);
		model_rsp = apply_request(q);
		rsp_due.push_back(typed ? want : model_rsp);
	endtask

	// lets a fade sweep finish before the gain changes
	task automatic wait_quiet();
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (apbf_pkg::PIXEL_COUNT + 8) @(posedge clk);
	endtask

	task automatic set_gain(input gain_t g);
		req_valid <= 1'b0;
		wait_quiet();
		cfg_wen <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_wen <= 1'b0;
		gain_model = g;
	endtask

	initial begin
		gain_t phase_gain [PHASES];
		int per_phase;
		foreach (frame_model[i])
			frame_model[i] = '0;
		phase_gain[0] = 9'd511;
		phase_gain[1] = 9'd0;
		phase_gain[2] = 9'd255;
		phase_gain[3] = 9'd1;
		phase_gain[4] = 9'd128;
		phase_gain[5] = gain_t'($urandom_range(0, 511));
		phase_gain[6] = gain_t'($urandom_range(0, 511));
		phase_gain[7] = 9'd384;
		per_phase = RAND_ITEMS / PHASES;

		add_row(apbf_pkg::REQ_READ, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_READ, 1023, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_READ, 1024, 0, 0, 0, 1, 0, 0, 0, 1);
		add_row(apbf_pkg::REQ_READ, 4095, 255, 255, 255, 1, 0, 0, 0, 1);
		add_row(apbf_pkg::REQ_ADD, 4095, 255, 255, 255, 1, 0, 0, 0, 1);
		add_row(apbf_pkg::REQ_ADD, 1024, 1, 2, 3, 1, 0, 0, 0, 1);
		add_row(apbf_pkg::REQ_ADD, 0, 255, 255, 255, 1, 255, 255, 255, 0);
		add_row(apbf_pkg::REQ_ADD, 0, 1, 1, 1, 1, 255, 255, 255, 0);
		add_row(apbf_pkg::REQ_ADD, 1023, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_ADD, 5, 100, 200, 7, 0, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_ADD, 5, 200, 60, 255, 0, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_ADD, 682, 'h55, 'hAA, 'h80, 0, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_ADD, 341, 'hAA, 'h55, 'h7F, 0, 0, 0, 0, 0);
		add_row(REQ_RSVD, 'hABC, 9, 9, 9, 1, 0, 0, 0, 1);
		add_row(REQ_RSVD, 0, 0, 0, 0, 1, 0, 0, 0, 1);
		add_row(apbf_pkg::REQ_FADE, 'h555, 255, 255, 255, 1, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_READ, 682, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_FADE, 'hFFF, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(apbf_pkg::REQ_READ, 341, 0, 0, 0, 0, 0, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

		for (int p = 0; p < PHASES; p++) begin
			set_gain(phase_gain[p]);
			for (int k = 0; k < per_phase; k++) begin
				if (p == PHASES - 1 && k == per_phase - CALM_ITEMS)
					calm = 1'b1;
				send_beat(make_random_req(), 1'b0, '0);
			end
		end

		req_valid <= 1'b0;
		wait_quiet();
		if (mismatches == 0 && rsp_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/apbf_pkg.sv
sv/apbf_ctrl.sv
sv/apbf_dp.sv
sv/additive_pixel_buffer_with_fade.sv
tb/sv/tb_additive_pixel_buffer_with_fade.sv
